@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the UART ring buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the first expression holds, the second holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/utrb_pkg.sv @@
// ----------------------------------------------------------------------------
// utrb_pkg
// Types and constants shared by the UART ring buffer modules.
// ----------------------------------------------------------------------------
package utrb_pkg;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_LINE  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam int NUM_CNT     = 5;
    localparam int CNT_OVERRUN = 0;
    localparam int CNT_RECEIVED = 1;
    localparam int CNT_DROPPED = 2;
    localparam int CNT_SENT    = 3;
    localparam int CNT_WAIT    = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_LINE,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       is_lf;
        logic [7:0] data_byte;
        logic       write_last;
        logic       overrun_flag;
        logic       rx_ready_flag;
        logic [7:0] line_rx_byte;
        logic       tx_empty_flag;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic {
        ST_RUN,
        ST_LF
    } back_state_t;

endpackage

@@ hdl/utrb_front.sv @@
// ----------------------------------------------------------------------------
// utrb_front
// Accepts request transfers and classifies them into queue commands.
// ----------------------------------------------------------------------------
module utrb_front (
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [7:0]         data_byte,
    input  logic               write_last,
    input  logic               overrun_flag,
    input  logic               rx_ready_flag,
    input  logic [7:0]         line_rx_byte,
    input  logic               tx_empty_flag,
    input  utrb_pkg::q_status_t q_status,
    output logic               push,
    output utrb_pkg::cmd_t     cmd
);
    import utrb_pkg::*;

    assign busy = q_status.full;
    assign push = start && !q_status.full;

    always_comb
    begin
        unique case (req_type)
            REQ_WRITE: cmd.kind = CMD_WRITE;
            REQ_LINE:  cmd.kind = CMD_LINE;
            REQ_READ:  cmd.kind = CMD_READ;
            default:   cmd.kind = CMD_NOP;
        endcase
        cmd.is_lf         = (data_byte == CH_LF);
        cmd.data_byte     = data_byte;
        cmd.write_last    = write_last;
        cmd.overrun_flag  = overrun_flag;
        cmd.rx_ready_flag = rx_ready_flag;
        cmd.line_rx_byte  = line_rx_byte;
        cmd.tx_empty_flag = tx_empty_flag;
    end

endmodule

@@ hdl/utrb_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// utrb_cmd_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module utrb_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  utrb_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output utrb_pkg::cmd_t      head_cmd,
    output utrb_pkg::q_status_t status
);
    import utrb_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

@@ hdl/utrb_back.sv @@
// ----------------------------------------------------------------------------
// utrb_back
// Executes queued commands against the transmit ring, the receive queue
// and the statistics counters, and drives the result ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utrb_back #(
    parameter int TX_RING_DEPTH  = 256,
    parameter int RX_QUEUE_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  utrb_pkg::cmd_t      head_cmd,
    input  utrb_pkg::q_status_t q_status,
    output logic                pop,
    output logic                done,
    output logic                accepted,
    output logic                tx_valid,
    output logic [7:0]          tx_byte,
    output logic                read_valid,
    output logic [7:0]          read_byte,
    output logic                tx_irq_enabled,
    output logic [31:0]         overrun_total,
    output logic [31:0]         received_total,
    output logic [31:0]         dropped_total,
    output logic [31:0]         sent_total,
    output logic [31:0]         wait_total
);
    import utrb_pkg::*;

    localparam int TXW  = $clog2(TX_RING_DEPTH);
    localparam int RXW  = $clog2(RX_QUEUE_DEPTH);
    localparam int RXCW = $clog2(RX_QUEUE_DEPTH + 1);

    back_state_t state_reg;
    back_state_t state_next;

    logic [7:0] tx_mem [TX_RING_DEPTH];
    logic [7:0] rx_mem [RX_QUEUE_DEPTH];

    logic [TXW-1:0]  tx_wr_ptr_reg;
    logic [TXW-1:0]  tx_wr_ptr_next;
    logic [TXW-1:0]  tx_rd_ptr_reg;
    logic [TXW-1:0]  tx_rd_ptr_next;
    logic [TXW-1:0]  tx_count_reg;
    logic [TXW-1:0]  tx_count_next;
    logic [TXW-1:0]  lf_ptr_reg;
    logic [TXW-1:0]  lf_ptr_next;
    logic [RXW-1:0]  rx_wr_ptr_reg;
    logic [RXW-1:0]  rx_wr_ptr_next;
    logic [RXW-1:0]  rx_rd_ptr_reg;
    logic [RXW-1:0]  rx_rd_ptr_next;
    logic [RXCW-1:0] rx_count_reg;
    logic [RXCW-1:0] rx_count_next;
    logic            tx_en_reg;
    logic            tx_en_next;
    logic [31:0]     cnt_reg [NUM_CNT];
    logic [31:0]     cnt_next [NUM_CNT];

    logic [TXW-1:0]  tx_wp1;
    logic [TXW-1:0]  tx_wp2;
    logic [TXW-1:0]  tx_rp1;
    logic [RXW-1:0]  rx_wp1;
    logic [RXW-1:0]  rx_rp1;
    logic            tx_fits;
    logic            lf_start;

    logic            tx_we;
    logic [TXW-1:0]  tx_waddr;
    logic [7:0]      tx_wdata;
    logic            tx_re;
    logic            rx_we;
    logic            rx_re;
    logic [7:0]      tx_rdata_reg;
    logic [7:0]      rx_rdata_reg;

    logic            acc_now;
    logic            txv_now;
    logic            rdv_now;
    logic            s1_valid_reg;
    logic            s1_acc_reg;
    logic            s1_txv_reg;
    logic            s1_rdv_reg;

    logic            done_reg;
    logic            acc_out_reg;
    logic            txv_out_reg;
    logic [7:0]      txb_out_reg;
    logic            rdv_out_reg;
    logic [7:0]      rdb_out_reg;
    logic            irq_out_reg;
    logic [31:0]     cnt_out_reg [NUM_CNT];

    assign tx_wp1 = (tx_wr_ptr_reg == TXW'(TX_RING_DEPTH - 1)) ? '0 : tx_wr_ptr_reg + 1'b1;
    assign tx_wp2 = (tx_wp1 == TXW'(TX_RING_DEPTH - 1)) ? '0 : tx_wp1 + 1'b1;
    assign tx_rp1 = (tx_rd_ptr_reg == TXW'(TX_RING_DEPTH - 1)) ? '0 : tx_rd_ptr_reg + 1'b1;
    assign rx_wp1 = (rx_wr_ptr_reg == RXW'(RX_QUEUE_DEPTH - 1)) ? '0 : rx_wr_ptr_reg + 1'b1;
    assign rx_rp1 = (rx_rd_ptr_reg == RXW'(RX_QUEUE_DEPTH - 1)) ? '0 : rx_rd_ptr_reg + 1'b1;

    // The ring keeps one slot empty, and a newline needs room for CR and LF.
    assign tx_fits = ({1'b0, tx_count_reg} + (head_cmd.is_lf ? (TXW+1)'(2) : (TXW+1)'(1)))
                     <= (TXW+1)'(TX_RING_DEPTH - 1);
    assign lf_start = pop && (head_cmd.kind == CMD_WRITE) && head_cmd.is_lf && tx_fits;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (lf_start)
                begin
                    state_next = ST_LF;
                end
            end
            ST_LF:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        pop = (state_reg == ST_RUN) && !q_status.empty;
    end

    always_comb
    begin
        tx_wr_ptr_next = tx_wr_ptr_reg;
        tx_rd_ptr_next = tx_rd_ptr_reg;
        tx_count_next  = tx_count_reg;
        lf_ptr_next    = lf_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        rx_count_next  = rx_count_reg;
        tx_en_next     = tx_en_reg;
        for (int i = 0; i < NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        tx_we    = 1'b0;
        tx_waddr = tx_wr_ptr_reg;
        tx_wdata = head_cmd.data_byte;
        tx_re    = 1'b0;
        rx_we    = 1'b0;
        rx_re    = 1'b0;
        acc_now  = 1'b0;
        txv_now  = 1'b0;
        rdv_now  = 1'b0;

        if (state_reg == ST_LF)
        begin
            tx_we    = 1'b1;
            tx_waddr = lf_ptr_reg;
            tx_wdata = CH_LF;
        end
        else if (pop)
        begin
            unique case (head_cmd.kind)
                CMD_WRITE:
                begin
                    if (tx_fits)
                    begin
                        acc_now = 1'b1;
                        tx_we   = 1'b1;
                        if (head_cmd.is_lf)
                        begin
                            tx_wdata       = CH_CR;
                            lf_ptr_next    = tx_wp1;
                            tx_wr_ptr_next = tx_wp2;
                            tx_count_next  = tx_count_reg + TXW'(2);
                        end
                        else
                        begin
                            tx_wr_ptr_next = tx_wp1;
                            tx_count_next  = tx_count_reg + 1'b1;
                        end
                        if (head_cmd.write_last)
                        begin
                            tx_en_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next[CNT_WAIT] = cnt_reg[CNT_WAIT] + 32'd1;
                        tx_en_next         = 1'b1;
                    end
                end
                CMD_LINE:
                begin
                    if (head_cmd.overrun_flag)
                    begin
                        cnt_next[CNT_OVERRUN] = cnt_reg[CNT_OVERRUN] + 32'd1;
                    end
                    if (head_cmd.rx_ready_flag)
                    begin
                        cnt_next[CNT_RECEIVED] = cnt_reg[CNT_RECEIVED] + 32'd1;
                        if (rx_count_reg < RXCW'(RX_QUEUE_DEPTH))
                        begin
                            rx_we          = 1'b1;
                            rx_wr_ptr_next = rx_wp1;
                            rx_count_next  = rx_count_reg + 1'b1;
                        end
                        else
                        begin
                            cnt_next[CNT_DROPPED] = cnt_reg[CNT_DROPPED] + 32'd1;
                        end
                    end
                    if (tx_en_reg && head_cmd.tx_empty_flag)
                    begin
                        if (tx_count_reg != '0)
                        begin
                            txv_now            = 1'b1;
                            tx_re              = 1'b1;
                            tx_rd_ptr_next     = tx_rp1;
                            tx_count_next      = tx_count_reg - 1'b1;
                            cnt_next[CNT_SENT] = cnt_reg[CNT_SENT] + 32'd1;
                        end
                        else
                        begin
                            tx_en_next = 1'b0;
                        end
                    end
                end
                CMD_READ:
                begin
                    if (rx_count_reg != '0)
                    begin
                        rdv_now        = 1'b1;
                        rx_re          = 1'b1;
                        rx_rd_ptr_next = rx_rp1;
                        rx_count_next  = rx_count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            tx_wr_ptr_reg <= '0;
            tx_rd_ptr_reg <= '0;
            tx_count_reg  <= '0;
            lf_ptr_reg    <= '0;
            rx_wr_ptr_reg <= '0;
            rx_rd_ptr_reg <= '0;
            rx_count_reg  <= '0;
            tx_en_reg     <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i]     <= '0;
                cnt_out_reg[i] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            acc_out_reg   <= 1'b0;
            txv_out_reg   <= 1'b0;
            rdv_out_reg   <= 1'b0;
            irq_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            tx_count_reg  <= tx_count_next;
            lf_ptr_reg    <= lf_ptr_next;
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            rx_count_reg  <= rx_count_next;
            tx_en_reg     <= tx_en_next;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            s1_valid_reg  <= pop;
            done_reg      <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                acc_out_reg <= s1_acc_reg;
                txv_out_reg <= s1_txv_reg;
                rdv_out_reg <= s1_rdv_reg;
                irq_out_reg <= tx_en_reg;
                for (int i = 0; i < NUM_CNT; i++)
                begin
                    cnt_out_reg[i] <= cnt_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_acc_reg <= acc_now;
        s1_txv_reg <= txv_now;
        s1_rdv_reg <= rdv_now;
        if (s1_valid_reg)
        begin
            txb_out_reg <= s1_txv_reg ? tx_rdata_reg : 8'd0;
            rdb_out_reg <= s1_rdv_reg ? rx_rdata_reg : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_waddr] <= tx_wdata;
        end
        if (tx_re)
        begin
            tx_rdata_reg <= tx_mem[tx_rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_wr_ptr_reg] <= head_cmd.line_rx_byte;
        end
        if (rx_re)
        begin
            rx_rdata_reg <= rx_mem[rx_rd_ptr_reg];
        end
    end

    assign done           = done_reg;
    assign accepted       = acc_out_reg;
    assign tx_valid       = txv_out_reg;
    assign tx_byte        = txb_out_reg;
    assign read_valid     = rdv_out_reg;
    assign read_byte      = rdb_out_reg;
    assign tx_irq_enabled = irq_out_reg;
    assign overrun_total  = cnt_out_reg[CNT_OVERRUN];
    assign received_total = cnt_out_reg[CNT_RECEIVED];
    assign dropped_total  = cnt_out_reg[CNT_DROPPED];
    assign sent_total     = cnt_out_reg[CNT_SENT];
    assign wait_total     = cnt_out_reg[CNT_WAIT];

    `ASSERT_ALWAYS(a_tx_level, clk, rst_n, tx_count_reg <= TXW'(TX_RING_DEPTH - 1), "tx ring overfilled")
    `ASSERT_ALWAYS(a_tx_empty, clk, rst_n, (tx_count_reg == '0) == (tx_rd_ptr_reg == tx_wr_ptr_reg), "tx level and pointers disagree")
    `ASSERT_ALWAYS(a_rx_level, clk, rst_n, rx_count_reg <= RXCW'(RX_QUEUE_DEPTH), "rx queue overfilled")
    `ASSERT_NEXT(a_lf_step, clk, rst_n, state_reg == ST_LF, state_reg == ST_RUN && !s1_valid_reg, "newline store step misbehaved")

endmodule

@@ hdl/uart_tx_rx_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffer
// Two-way UART byte buffer: transmit ring, receive queue and statistics.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_type .. tx_empty_flag
// result    out        done strobe, one cycle    accepted .. wait_total
//
// A request transfer enters a two-entry command queue; the back end takes one
// command per cycle, except while a stored newline occupies it, since CR and LF
// go through the single write port of the transmit ring memory.
// With an empty queue a request is written to a queue entry and popped by the
// back end, and its result passes the s1 and output registers before done rises.
// busy is high while both queue entries are taken.
// Reset clears pointers, levels, enable and counters at once; no memory sweep.
// The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffer #(
    parameter int TX_RING_DEPTH  = 256,
    parameter int RX_QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    input  logic        write_last,
    input  logic        overrun_flag,
    input  logic        rx_ready_flag,
    input  logic [7:0]  line_rx_byte,
    input  logic        tx_empty_flag,
    output logic        done,
    output logic        accepted,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        read_valid,
    output logic [7:0]  read_byte,
    output logic        tx_irq_enabled,
    output logic [31:0] overrun_total,
    output logic [31:0] received_total,
    output logic [31:0] dropped_total,
    output logic [31:0] sent_total,
    output logic [31:0] wait_total
);
    import utrb_pkg::*;

    q_status_t q_status;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      push;
    logic      pop;

    utrb_front u_front (
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .data_byte     (data_byte),
        .write_last    (write_last),
        .overrun_flag  (overrun_flag),
        .rx_ready_flag (rx_ready_flag),
        .line_rx_byte  (line_rx_byte),
        .tx_empty_flag (tx_empty_flag),
        .q_status      (q_status),
        .push          (push),
        .cmd           (push_cmd)
    );

    utrb_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    utrb_back #(
        .TX_RING_DEPTH  (TX_RING_DEPTH),
        .RX_QUEUE_DEPTH (RX_QUEUE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_cmd       (head_cmd),
        .q_status       (q_status),
        .pop            (pop),
        .done           (done),
        .accepted       (accepted),
        .tx_valid       (tx_valid),
        .tx_byte        (tx_byte),
        .read_valid     (read_valid),
        .read_byte      (read_byte),
        .tx_irq_enabled (tx_irq_enabled),
        .overrun_total  (overrun_total),
        .received_total (received_total),
        .dropped_total  (dropped_total),
        .sent_total     (sent_total),
        .wait_total     (wait_total)
    );

endmodule
